@@ design/piaw_pkg.sv @@
// Shared types, constants and helpers for the PI regulator with anti-windup.
// No dependencies; imported by every module of the block.
package piaw_pkg;

    // Default fraction bits of values and gains
    localparam int FRAC_BITS_DEF = 16;
    // Setpoint weight is Q1.16
    localparam int ALPHA_FRAC = 16;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    localparam logic [16:0] ALPHA_RESET = ALPHA_ONE;

    // Shared multiplier operand and product widths
    localparam int OPA_W = 26;
    localparam int OPB_W = 34;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int WIDE_W = PROD_W + 1;

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam logic [2:0] REG_VARIANT = 3'd0;
    localparam logic [2:0] REG_PROP = 3'd1;
    localparam logic [2:0] REG_INTEG = 3'd2;
    localparam logic [2:0] REG_WINDUP = 3'd3;
    localparam logic [2:0] REG_ALPHA = 3'd4;
    localparam logic [2:0] REG_UPPER = 3'd5;
    localparam logic [2:0] REG_LOWER = 3'd6;

    // Variant codes
    localparam logic [1:0] VAR_FULL = 2'd0;
    localparam logic [1:0] VAR_PI_ONLY = 2'd1;
    localparam logic [1:0] VAR_NO_COMP = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]  variant;
        logic [23:0] prop_gain;
        logic [23:0] integ_gain;
        logic [23:0] windup_gain;
        logic [16:0] weight_alpha;
        logic [31:0] upper_limit;
        logic [31:0] lower_limit;
    } piaw_cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [31:0] r;
        if (x > WIDE_W'(S32_MAX)) begin
            r = S32_MAX;
        end else if (x < WIDE_W'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Upper test first; with crossed limits, values above the upper one resolve to it, others to the lower one
    function automatic logic signed [31:0] clamp_lim(input logic signed [WIDE_W-1:0] x,
                                                    input logic signed [31:0] hi,
                                                    input logic signed [31:0] lo);
        logic signed [31:0] r;
        if (x > WIDE_W'(hi)) begin
            r = hi;
        end else if (x < WIDE_W'(lo)) begin
            r = lo;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/pi_controller_antiwindup.sv @@
// Top level of the PI regulator with setpoint weighting and anti-windup.
// Depends on piaw_pkg; instantiates piaw_regs, piaw_mul and piaw_core.
//
// PI regulator, fixed point. Values are signed Q16.16 (FRAC_BITS fraction
// bits), gains unsigned Q8.16, the setpoint weight Q1.16. A run transaction
// (mode 0) updates the integrator with back-calculation anti-windup, forms
// the weighted P term plus integrator plus compensation, saturates to 32
// bits and clamps to [lower_limit, upper_limit]; the clamped drive is
// returned. A preset transaction (mode 1) loads the integrator unclamped and
// returns a drive of zero. Exactly one result transaction follows each input
// transaction. All products go through one shared 26x34 multiplier that a
// sequencer steps through six products. A run's result is valid once ST_AW,
// ST_KA, ST_KB, ST_INC, ST_P, ST_Q, ST_RAW and ST_OUT have passed, a
// preset's once ST_OUT has; s_ready is high only while the sequencer is
// idle, so the next transaction waits until the sequencer is back in
// ST_IDLE. A result still waiting on m_ready holds the following
// transaction in its last step until the result leaves. Registers sit on
// the APB port at 4*index (variant, prop_gain, integ_gain, windup_gain,
// weight_alpha, upper_limit, lower_limit); write them only while idle.
module pi_controller_antiwindup import piaw_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input transactions
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic signed [31:0] s_error,
    input  logic signed [31:0] s_feedback,
    input  logic signed [31:0] s_compensation,
    input  logic signed [31:0] s_preset_value,
    // result transactions
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_drive
);

    piaw_cfg_t                cfg;
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    // register file; the user must keep values stable while a transaction is in work, the block does not enforce it
    piaw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the one multiplier, product registered for the next step
    piaw_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    // sequencer: anti-windup, gains, integrator, P terms, saturate, clamp
    piaw_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_error        (s_error),
        .s_feedback     (s_feedback),
        .s_compensation (s_compensation),
        .s_preset_value (s_preset_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive),
        .mul_a          (mul_a),
        .mul_b          (mul_b),
        .mul_prod       (mul_prod)
    );

endmodule

@@ design/piaw_regs.sv @@
// APB configuration register file of the PI regulator.
// Depends on piaw_pkg for the register map and the configuration struct.
module piaw_regs import piaw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output piaw_cfg_t          cfg
);

    logic [1:0]  variant_reg;
    logic [23:0] prop_reg;
    logic [23:0] integ_reg;
    logic [23:0] windup_reg;
    logic [16:0] alpha_reg;
    logic [31:0] upper_reg;
    logic [31:0] lower_reg;
    logic [2:0]  idx;
    logic        wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= VAR_FULL;
            prop_reg    <= '0;
            integ_reg   <= '0;
            windup_reg  <= '0;
            alpha_reg   <= ALPHA_RESET;
            upper_reg   <= '0;
            lower_reg   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_VARIANT: variant_reg <= pwdata[1:0];
                REG_PROP:    prop_reg    <= pwdata[23:0];
                REG_INTEG:   integ_reg   <= pwdata[23:0];
                REG_WINDUP:  windup_reg  <= pwdata[23:0];
                REG_ALPHA:   alpha_reg   <= pwdata[16:0];
                REG_UPPER:   upper_reg   <= pwdata;
                REG_LOWER:   lower_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_VARIANT: prdata = PDATA_W'(variant_reg);
            REG_PROP:    prdata = PDATA_W'(prop_reg);
            REG_INTEG:   prdata = PDATA_W'(integ_reg);
            REG_WINDUP:  prdata = PDATA_W'(windup_reg);
            REG_ALPHA:   prdata = PDATA_W'(alpha_reg);
            REG_UPPER:   prdata = upper_reg;
            REG_LOWER:   prdata = lower_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.variant      = variant_reg;
    assign cfg.prop_gain    = prop_reg;
    assign cfg.integ_gain   = integ_reg;
    assign cfg.windup_gain  = windup_reg;
    assign cfg.weight_alpha = alpha_reg;
    assign cfg.upper_limit  = upper_reg;
    assign cfg.lower_limit  = lower_reg;

endmodule

@@ design/piaw_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on piaw_pkg for operand widths.
module piaw_mul import piaw_pkg::*; (
    input  logic                     aclk,
    input  logic signed [OPA_W-1:0]  mul_a,
    input  logic signed [OPB_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0] mul_prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_prod = prod_reg;

endmodule

@@ design/piaw_core.sv @@
// Sequencer and accumulate datapath of the PI regulator.
// Depends on piaw_pkg; drives the shared multiplier piaw_mul.
module piaw_core import piaw_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  piaw_cfg_t                cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic signed [31:0]       s_error,
    input  logic signed [31:0]       s_feedback,
    input  logic signed [31:0]       s_compensation,
    input  logic signed [31:0]       s_preset_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_drive,
    output logic signed [OPA_W-1:0]  mul_a,
    output logic signed [OPB_W-1:0]  mul_b,
    input  logic signed [PROD_W-1:0] mul_prod
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_AW   = 9'b000000010,
        ST_KA   = 9'b000000100,
        ST_KB   = 9'b000001000,
        ST_INC  = 9'b000010000,
        ST_P    = 9'b000100000,
        ST_Q    = 9'b001000000,
        ST_RAW  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t                   state_reg;
    logic                     m_valid_reg;
    logic signed [31:0]       m_drive_reg;
    logic                     preset_reg;
    logic signed [31:0]       integrator_reg;
    logic signed [31:0]       raw_reg;
    logic signed [31:0]       clamped_reg;
    logic signed [31:0]       err_reg;
    logic signed [31:0]       fbk_reg;
    logic signed [31:0]       comp_reg;
    logic signed [31:0]       t_reg;
    logic signed [OPA_W-1:0]  ka_reg;
    logic signed [OPA_W-1:0]  kb_reg;
    logic signed [WIDE_W-1:0] acc_reg;

    logic                     accept;
    logic                     out_free;
    logic                     pi_only;
    logic                     no_comp;
    logic [16:0]              alpha_eff;
    logic signed [17:0]       alpha_cmp;
    logic signed [32:0]       excess;
    logic signed [31:0]       comp_eff;
    logic signed [WIDE_W-1:0] prod_ext;
    logic signed [WIDE_W-1:0] prod_f;
    logic signed [WIDE_W-1:0] prod_a;
    logic signed [31:0]       drive_val;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;
    assign m_valid  = m_valid_reg;
    assign m_drive  = m_drive_reg;

    assign pi_only   = (cfg.variant == VAR_PI_ONLY);
    assign no_comp   = (cfg.variant == VAR_PI_ONLY) || (cfg.variant == VAR_NO_COMP);
    assign alpha_eff = pi_only ? ALPHA_ONE : cfg.weight_alpha;
    assign alpha_cmp = signed'({1'b0, ALPHA_ONE}) - signed'({1'b0, alpha_eff});
    assign excess    = 33'(raw_reg) - 33'(clamped_reg);
    assign comp_eff  = no_comp ? 32'sd0 : comp_reg;

    // floored products: arithmetic shift of the registered product
    assign prod_ext = {mul_prod[PROD_W-1], mul_prod};
    assign prod_f   = prod_ext >>> FRAC_BITS;
    assign prod_a   = prod_ext >>> ALPHA_FRAC;

    assign drive_val = preset_reg ? 32'sd0
                     : clamp_lim(WIDE_W'(raw_reg), cfg.upper_limit, cfg.lower_limit);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_AW: begin
                mul_a = signed'(OPA_W'(cfg.windup_gain));
                mul_b = pi_only ? '0 : OPB_W'(excess);
            end
            ST_KA: begin
                mul_a = signed'(OPA_W'(alpha_eff));
                mul_b = signed'(OPB_W'(cfg.prop_gain));
            end
            ST_KB: begin
                mul_a = OPA_W'(alpha_cmp);
                mul_b = signed'(OPB_W'(cfg.prop_gain));
            end
            ST_INC: begin
                mul_a = signed'(OPA_W'(cfg.integ_gain));
                mul_b = OPB_W'(t_reg);
            end
            ST_P: begin
                mul_a = ka_reg;
                mul_b = OPB_W'(err_reg);
            end
            ST_Q: begin
                mul_a = kb_reg;
                mul_b = OPB_W'(fbk_reg);
            end
            default: ;
        endcase
    end

    // control and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            preset_reg     <= 1'b0;
            integrator_reg <= '0;
            raw_reg        <= '0;
            clamped_reg    <= '0;
        end else begin
            // in ST_OUT the handoff below owns the valid flag
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        preset_reg <= s_mode;
                        if (s_mode) begin
                            integrator_reg <= s_preset_value;
                            raw_reg        <= '0;
                            clamped_reg    <= '0;
                            state_reg      <= ST_OUT;
                        end else begin
                            state_reg <= ST_AW;
                        end
                    end
                end
                ST_AW:  state_reg <= ST_KA;
                ST_KA:  state_reg <= ST_KB;
                ST_KB:  state_reg <= ST_INC;
                ST_INC: state_reg <= ST_P;
                ST_P: begin
                    integrator_reg <= clamp_lim(WIDE_W'(integrator_reg) + prod_f,
                                                cfg.upper_limit, cfg.lower_limit);
                    state_reg <= ST_Q;
                end
                ST_Q:   state_reg <= ST_RAW;
                ST_RAW: begin
                    raw_reg   <= sat32(acc_reg - prod_f);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        clamped_reg <= drive_val;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg  <= s_error;
            fbk_reg  <= s_feedback;
            comp_reg <= s_compensation;
        end
        if (state_reg == ST_KA) begin
            t_reg <= sat32(WIDE_W'(err_reg) - prod_f);
        end
        if (state_reg == ST_KB) begin
            ka_reg <= prod_a[OPA_W-1:0];
        end
        if (state_reg == ST_INC) begin
            kb_reg <= prod_a[OPA_W-1:0];
        end
        if (state_reg == ST_Q) begin
            acc_reg <= prod_f + WIDE_W'(integrator_reg) + WIDE_W'(comp_eff);
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_drive_reg <= drive_val;
        end
    end

endmodule
